/* sv/tpd_pkg.sv */
// ----------------------------------------------------------------------------
// tpd_pkg: shared types and constants for the terminal palette downgrade core
// Item layouts, color kind and depth codes, the controller/datapath command
// and status groups, and the 256-entry palette lookup.
// ----------------------------------------------------------------------------
package tpd_pkg;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_INDEX = 2'd1;
	localparam logic [1:0] KIND_RGB   = 2'd2;

	localparam logic [1:0] DEPTH_TRUE  = 2'd0;
	localparam logic [1:0] DEPTH_256   = 2'd1;
	localparam logic [1:0] DEPTH_16    = 2'd2;
	localparam logic [1:0] DEPTH_MONO  = 2'd3;

	// Candidate ranges of the nearest search
	localparam logic [7:0] CUBE_FIRST = 8'd16;
	localparam logic [7:0] CUBE_LAST  = 8'd255;
	localparam logic [7:0] SYS_FIRST  = 8'd0;
	localparam logic [7:0] SYS_LAST   = 8'd15;
	localparam logic [7:0] GRAY_FIRST = 8'd232;

	localparam int DIST_W = 18;

	typedef struct packed {
		logic [1:0] color_kind;
		logic [7:0] palette_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} in_item_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_index;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} out_item_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_search;
		logic last_cand;
		logic pipe_empty;
	} dp_status_t;

	localparam rgb_t SYS16 [16] = '{
		24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
		24'h0000EE, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5,
		24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
		24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
	};

	function automatic logic [7:0] cube_level(logic [2:0] x);
		logic [7:0] lvl;
		lvl = (x == 3'd0) ? 8'd0 : 8'(8'd55 + 8'({5'd0, x}) * 8'd40);
		return lvl;
	endfunction

	// Palette RGB of any index; a cube offset (0..215) is split into base-6 digits by threshold compares
	function automatic rgb_t palette_rgb(logic [7:0] idx);
		rgb_t       c;
		logic [7:0] v;
		logic [7:0] gray;
		logic [2:0] dr;
		logic [2:0] dg;
		logic [2:0] db;
		logic [5:0] rem;
		v = 8'(idx - CUBE_FIRST);
		if (v >= 8'd180)      dr = 3'd5;
		else if (v >= 8'd144) dr = 3'd4;
		else if (v >= 8'd108) dr = 3'd3;
		else if (v >= 8'd72)  dr = 3'd2;
		else if (v >= 8'd36)  dr = 3'd1;
		else                  dr = 3'd0;
		rem = 6'(v - 8'({5'd0, dr}) * 8'd36);
		if (rem >= 6'd30)      dg = 3'd5;
		else if (rem >= 6'd24) dg = 3'd4;
		else if (rem >= 6'd18) dg = 3'd3;
		else if (rem >= 6'd12) dg = 3'd2;
		else if (rem >= 6'd6)  dg = 3'd1;
		else                   dg = 3'd0;
		db = 3'(rem - 6'({3'd0, dg}) * 6'd6);
		gray = 8'(8'd8 + 8'(idx - GRAY_FIRST) * 8'd10);
		if (idx < CUBE_FIRST) begin
			c = SYS16[idx[3:0]];
		end else if (idx < GRAY_FIRST) begin
			c.r = cube_level(dr);
			c.g = cube_level(dg);
			c.b = cube_level(db);
		end else begin
			c.r = gray;
			c.g = gray;
			c.b = gray;
		end
		return c;
	endfunction

endpackage

/* sv/tpd_stream_if.sv */
// ----------------------------------------------------------------------------
// tpd_stream_if: valid/ready channel
// Carries one request per handshake; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface tpd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* sv/tpd_ctrl.sv */
// ----------------------------------------------------------------------------
// tpd_ctrl: sequencing controller
// Accepts a request, runs the candidate scan when needed, drains the
// distance pipeline and loads the output register.
// ----------------------------------------------------------------------------
module tpd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  tpd_pkg::dp_status_t    status,
	output tpd_pkg::ctrl_cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_WRITE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = status.need_search ? ST_SCAN : ST_WRITE;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (status.last_cand) state_nxt = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (status.pipe_empty) state_nxt = ST_WRITE;
			end
			ST_WRITE: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* sv/tpd_dp.sv */
// ----------------------------------------------------------------------------
// tpd_dp: color datapath
// Captures the request, steps a candidate counter through a three-stage
// distance pipeline, keeps the running minimum and builds the result.
// ----------------------------------------------------------------------------
module tpd_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           depth_mode,
	input  tpd_pkg::in_item_t    in_item,
	input  tpd_pkg::ctrl_cmd_t   cmd,
	output tpd_pkg::dp_status_t  status,
	output tpd_pkg::out_item_t   out_item
);

	logic                      kind_valid;
	logic                      search_cube;
	logic                      search_sys;
	logic [1:0]                res_kind_nxt;

	logic [1:0]                res_kind_q;
	logic [7:0]                res_idx_q;
	tpd_pkg::rgb_t             target_q;
	logic [7:0]                cand_q;
	logic [7:0]                last_q;
	logic [tpd_pkg::DIST_W-1:0] best_q;

	tpd_pkg::rgb_t             cand_rgb_s1;
	logic [7:0]                cand_idx_s1;
	logic                      v_s1;

	logic [15:0]               sq_r_s2;
	logic [15:0]               sq_g_s2;
	logic [15:0]               sq_b_s2;
	logic [7:0]                cand_idx_s2;
	logic                      v_s2;

	logic [7:0]                dr;
	logic [7:0]                dg;
	logic [7:0]                db;
	logic [tpd_pkg::DIST_W-1:0] dist_sum;

	tpd_pkg::out_item_t        out_q;

	// Decide the result kind and the search range from the incoming request
	always_comb begin
		kind_valid = (in_item.color_kind == tpd_pkg::KIND_INDEX) ||
			(in_item.color_kind == tpd_pkg::KIND_RGB);
		search_cube = kind_valid && (depth_mode == tpd_pkg::DEPTH_256) &&
			(in_item.color_kind == tpd_pkg::KIND_RGB);
		search_sys = kind_valid && (depth_mode == tpd_pkg::DEPTH_16) &&
			((in_item.color_kind == tpd_pkg::KIND_RGB) ||
			(in_item.palette_index >= tpd_pkg::CUBE_FIRST));
		res_kind_nxt = tpd_pkg::KIND_NONE;
		if (kind_valid) begin
			unique case (depth_mode)
				tpd_pkg::DEPTH_TRUE: res_kind_nxt = in_item.color_kind;
				tpd_pkg::DEPTH_256:  res_kind_nxt = tpd_pkg::KIND_INDEX;
				tpd_pkg::DEPTH_16:   res_kind_nxt = tpd_pkg::KIND_INDEX;
				default:             res_kind_nxt = tpd_pkg::KIND_NONE;
			endcase
		end
	end

	assign status.need_search = search_cube || search_sys;
	assign status.last_cand   = (cand_q == last_q);
	assign status.pipe_empty  = !v_s1 && !v_s2;

	// Distance of the candidate in stage two
	always_comb begin
		dr = (cand_rgb_s1.r > target_q.r) ? 8'(cand_rgb_s1.r - target_q.r) :
			8'(target_q.r - cand_rgb_s1.r);
		dg = (cand_rgb_s1.g > target_q.g) ? 8'(cand_rgb_s1.g - target_q.g) :
			8'(target_q.g - cand_rgb_s1.g);
		db = (cand_rgb_s1.b > target_q.b) ? 8'(cand_rgb_s1.b - target_q.b) :
			8'(target_q.b - cand_rgb_s1.b);
		dist_sum = tpd_pkg::DIST_W'(sq_r_s2) + tpd_pkg::DIST_W'(sq_g_s2) +
			tpd_pkg::DIST_W'(sq_b_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.step;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_kind_q <= res_kind_nxt;
			res_idx_q  <= in_item.palette_index;
			if (in_item.color_kind == tpd_pkg::KIND_RGB) begin
				target_q.r <= in_item.red;
				target_q.g <= in_item.green;
				target_q.b <= in_item.blue;
			end else begin
				target_q <= tpd_pkg::palette_rgb(in_item.palette_index);
			end
			cand_q <= search_cube ? tpd_pkg::CUBE_FIRST : tpd_pkg::SYS_FIRST;
			last_q <= search_cube ? tpd_pkg::CUBE_LAST : tpd_pkg::SYS_LAST;
			best_q <= '1;
		end else begin
			if (cmd.step) cand_q <= 8'(cand_q + 8'd1);
			// Strict compare keeps the lowest index on ties
			if (v_s2 && (dist_sum < best_q)) begin
				best_q    <= dist_sum;
				res_idx_q <= cand_idx_s2;
			end
		end
		cand_rgb_s1 <= tpd_pkg::palette_rgb(cand_q);
		cand_idx_s1 <= cand_q;
		sq_r_s2     <= 16'(16'(dr) * 16'(dr));
		sq_g_s2     <= 16'(16'(dg) * 16'(dg));
		sq_b_s2     <= 16'(16'(db) * 16'(db));
		cand_idx_s2 <= cand_idx_s1;
		if (cmd.emit) begin
			out_q.out_kind  <= res_kind_q;
			out_q.out_index <= (res_kind_q == tpd_pkg::KIND_INDEX) ? res_idx_q : 8'd0;
			out_q.out_red   <= (res_kind_q == tpd_pkg::KIND_RGB) ? target_q.r : 8'd0;
			out_q.out_green <= (res_kind_q == tpd_pkg::KIND_RGB) ? target_q.g : 8'd0;
			out_q.out_blue  <= (res_kind_q == tpd_pkg::KIND_RGB) ? target_q.b : 8'd0;
		end
	end

	assign out_item = out_q;

endmodule

/* sv/terminal_palette_downgrade_core.sv */
// ----------------------------------------------------------------------------
// terminal_palette_downgrade_core: color depth reduction for terminals
// Reduces one color request to the depth held in the depth_mode register.
// ----------------------------------------------------------------------------
// One request in, one result out. Truecolor depth passes the color through;
// 256-color depth maps RGB to the nearest cube or gray entry 16..255;
// 16-color depth maps RGB, or a palette index of 16 and up, to the nearest
// system color 0..15; monochrome depth and kind none give none. Ties pick the
// lowest index; unused result fields are zero. A request that needs no search
// goes from acceptance straight to the write state, which loads the output
// register once it is free. A search visits one candidate per cycle through
// one shared distance pipeline (palette lookup, squaring, compare), so a
// 256-color search covers 240 candidates and a 16-color search 16, and the
// pipeline drains before the write. The controller then returns to idle.
// A new request is taken once the previous one has reached the output
// register, while its result may still wait there for the consumer. Write
// depth_mode only while the block is idle.
// ----------------------------------------------------------------------------
module terminal_palette_downgrade_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	tpd_stream_if.sink  in_ch,
	tpd_stream_if.source out_ch
);

	logic                 [1:0] depth_mode_q;
	tpd_pkg::ctrl_cmd_t         cmd;
	tpd_pkg::dp_status_t        status;
	tpd_pkg::in_item_t          in_item;
	tpd_pkg::out_item_t         out_item;

	// Hold the target depth; reset to truecolor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_mode_q <= tpd_pkg::DEPTH_TRUE;
		end else if (cfg_wr_en) begin
			depth_mode_q <= cfg_wr_data;
		end
	end

	assign in_item = in_ch.payload;

	// Sequence the request: load, scan, drain, write out
	tpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Compute distances and hold the result register
	tpd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.depth_mode (depth_mode_q),
		.in_item    (in_item),
		.cmd        (cmd),
		.status     (status),
		.out_item   (out_item)
	);

	assign out_ch.payload = out_item;

endmodule

/* tb/terminal_palette_downgrade_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// terminal_palette_downgrade_core_tb: self-checking bench for the depth reducer
// Feeds none, index and RGB colors at every depth setting, predicts each
// reduced color, and compares it field by field under random back-pressure.
// ----------------------------------------------------------------------------

class downgrade_scoreboard;
	logic [1:0]          depth;
	tpd_pkg::rgb_t       sys_colors [16];
	tpd_pkg::out_item_t  pending_colors [$];
	int                  mismatches;
	int                  checked;

	function new();
		depth = tpd_pkg::DEPTH_TRUE;
		mismatches = 0;
		checked = 0;
		sys_colors = '{
			'{8'd0, 8'd0, 8'd0},       '{8'd205, 8'd0, 8'd0},
			'{8'd0, 8'd205, 8'd0},     '{8'd205, 8'd205, 8'd0},
			'{8'd0, 8'd0, 8'd238},     '{8'd205, 8'd0, 8'd205},
			'{8'd0, 8'd205, 8'd205},   '{8'd229, 8'd229, 8'd229},
			'{8'd127, 8'd127, 8'd127}, '{8'd255, 8'd0, 8'd0},
			'{8'd0, 8'd255, 8'd0},     '{8'd255, 8'd255, 8'd0},
			'{8'd92, 8'd92, 8'd255},   '{8'd255, 8'd0, 8'd255},
			'{8'd0, 8'd255, 8'd255},   '{8'd255, 8'd255, 8'd255}
		};
	endfunction

	function int cube_step(int x);
		return (x == 0) ? 0 : 55 + 40 * x;
	endfunction

	function tpd_pkg::rgb_t entry_rgb(int idx);
		tpd_pkg::rgb_t e;
		int            v;
		if (idx < 16) begin
			e = sys_colors[idx];
		end else if (idx < 232) begin
			v = idx - 16;
			e.r = 8'(cube_step(v / 36));
			e.g = 8'(cube_step((v / 6) % 6));
			e.b = 8'(cube_step(v % 6));
		end else begin
			v = 8 + (idx - 232) * 10;
			e = '{8'(v), 8'(v), 8'(v)};
		end
		return e;
	endfunction

	// strict compare keeps the lowest index on a tie
	function logic [7:0] closest_entry(tpd_pkg::rgb_t c, int lo, int hi);
		int            best;
		int            pick;
		int            d;
		tpd_pkg::rgb_t e;
		best = 32'h7fffffff;
		pick = lo;
		for (int i = lo; i < hi; i++) begin
			e = entry_rgb(i);
			d = (int'(c.r) - int'(e.r)) ** 2 + (int'(c.g) - int'(e.g)) ** 2
				+ (int'(c.b) - int'(e.b)) ** 2;
			if (d < best) begin
				best = d;
				pick = i;
			end
		end
		return 8'(pick);
	endfunction

	function tpd_pkg::out_item_t reduce_color(tpd_pkg::in_item_t c);
		tpd_pkg::out_item_t o;
		tpd_pkg::rgb_t      chan;
		o = '0;
		chan = '{c.red, c.green, c.blue};
		if (c.color_kind == tpd_pkg::KIND_INDEX || c.color_kind == tpd_pkg::KIND_RGB) begin
			case (depth)
				tpd_pkg::DEPTH_TRUE: begin
					o.out_kind = c.color_kind;
					if (c.color_kind == tpd_pkg::KIND_RGB) begin
						o.out_red = c.red;
						o.out_green = c.green;
						o.out_blue = c.blue;
					end else begin
						o.out_index = c.palette_index;
					end
				end
				tpd_pkg::DEPTH_256: begin
					o.out_kind = tpd_pkg::KIND_INDEX;
					o.out_index = (c.color_kind == tpd_pkg::KIND_RGB) ?
						closest_entry(chan, 16, 256) : c.palette_index;
				end
				tpd_pkg::DEPTH_16: begin
					o.out_kind = tpd_pkg::KIND_INDEX;
					if (c.color_kind == tpd_pkg::KIND_RGB)
						o.out_index = closest_entry(chan, 0, 16);
					else if (c.palette_index >= 8'd16)
						o.out_index = closest_entry(entry_rgb(c.palette_index), 0, 16);
					else
						o.out_index = c.palette_index;
				end
				default: o.out_kind = tpd_pkg::KIND_NONE;
			endcase
		end
		return o;
	endfunction

	function void note_color(tpd_pkg::in_item_t c);
		pending_colors.push_back(reduce_color(c));
	endfunction

	task report_mismatch(string what, int got, int want);
		mismatches++;
		$display("MISMATCH t=%0t %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task check_color(tpd_pkg::out_item_t got);
		tpd_pkg::out_item_t want;
		if (pending_colors.size() == 0) begin
			report_mismatch("unexpected result, kind", got.out_kind, -1);
			return;
		end
		want = pending_colors.pop_front();
		checked++;
		if (got.out_kind !== want.out_kind)
			report_mismatch("out_kind", got.out_kind, want.out_kind);
		if (got.out_index !== want.out_index)
			report_mismatch("out_index", got.out_index, want.out_index);
		if (got.out_red !== want.out_red)
			report_mismatch("out_red", got.out_red, want.out_red);
		if (got.out_green !== want.out_green)
			report_mismatch("out_green", got.out_green, want.out_green);
		if (got.out_blue !== want.out_blue)
			report_mismatch("out_blue", got.out_blue, want.out_blue);
	endtask
endclass

module terminal_palette_downgrade_core_tb;

	localparam logic [1:0] KIND_UNUSED = 2'd3;   // undefined kind code, reads as none
	localparam int SEGMENTS = 10;
	localparam int SEG_ITEMS = 65;
	localparam int HOLD_CYCLES = 400;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [1:0] cfg_wr_data;

	tpd_stream_if #(.payload_t(tpd_pkg::in_item_t))  in_ch ();
	tpd_stream_if #(.payload_t(tpd_pkg::out_item_t)) out_ch ();

	terminal_palette_downgrade_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch      (in_ch),
		.out_ch     (out_ch)
	);

	downgrade_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;
	int depth_writes = 0;
	int sent = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: several times the slowest legal run (every request a full
	// 256-color search behind a stalled consumer).
	initial begin
		#15_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Consumer side: check each accepted result, then pick ready for the next
	// edge. A hold-off request drops ready for a long stretch so the core fills
	// up and has to stall its input.
	initial begin
		int hold_left;
		hold_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				sb.check_color(out_ch.payload);
			if (!arst_n) begin
				out_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				out_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic tpd_pkg::in_item_t make_item(logic [1:0] kind, logic [7:0] idx,
			logic [7:0] r, logic [7:0] g, logic [7:0] b);
		tpd_pkg::in_item_t c;
		c.color_kind = kind;
		c.palette_index = idx;
		c.red = r;
		c.green = g;
		c.blue = b;
		return c;
	endfunction

	function automatic logic [7:0] nudge(logic [7:0] v);
		int n;
		n = int'(v) + $urandom_range(6) - 3;
		return (n < 0) ? 8'd0 : (n > 255) ? 8'd255 : 8'(n);
	endfunction

	// Mostly index and RGB requests; RGB lands on or near palette entries often
	// so ties and close calls come up, and on channel extremes now and then.
	function automatic tpd_pkg::in_item_t random_color();
		tpd_pkg::in_item_t c;
		tpd_pkg::rgb_t     e;
		int                pick;
		c = tpd_pkg::in_item_t'({$urandom, $urandom});
		pick = $urandom_range(99);
		if (pick < 6)       c.color_kind = tpd_pkg::KIND_NONE;
		else if (pick < 10) c.color_kind = KIND_UNUSED;
		else if (pick < 45) c.color_kind = tpd_pkg::KIND_INDEX;
		else                c.color_kind = tpd_pkg::KIND_RGB;
		pick = $urandom_range(99);
		if (pick < 30) begin
			e = sb.entry_rgb($urandom_range(255));
			c.red = nudge(e.r);
			c.green = nudge(e.g);
			c.blue = nudge(e.b);
		end else if (pick < 40) begin
			c.red = $urandom_range(1) ? 8'hFF : 8'h00;
			c.green = $urandom_range(1) ? 8'hFF : 8'h00;
			c.blue = $urandom_range(1) ? 8'hFF : 8'h00;
		end
		return c;
	endfunction

	// Offer one request, with an optional random gap first; keep valid high
	// across back-to-back requests.
	task automatic send_color(input tpd_pkg::in_item_t c);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= c;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_color(c);
		sent++;
	endtask

	// Hold the sender until every expected result is back, then let the
	// output register settle.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (sb.pending_colors.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_depth(input logic [1:0] d);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= d;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.depth = d;
		depth_writes++;
	endtask

	logic [1:0] seg_depth [SEGMENTS] = '{tpd_pkg::DEPTH_256, tpd_pkg::DEPTH_16,
		tpd_pkg::DEPTH_TRUE, tpd_pkg::DEPTH_MONO, tpd_pkg::DEPTH_16, tpd_pkg::DEPTH_256,
		tpd_pkg::DEPTH_16, tpd_pkg::DEPTH_TRUE, tpd_pkg::DEPTH_256, tpd_pkg::DEPTH_16};

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= tpd_pkg::DEPTH_TRUE;
		in_ch.valid <= 1'b0;
		in_ch.payload <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: truecolor straight out of reset, unused fields full of junk
		send_color(make_item(tpd_pkg::KIND_NONE, 8'hA5, 8'h11, 8'h22, 8'h33));
		send_color(make_item(tpd_pkg::KIND_INDEX, 8'd200, 8'hFF, 8'h00, 8'hFF));
		send_color(make_item(tpd_pkg::KIND_RGB, 8'h5A, 8'hA5, 8'h5A, 8'hC3));

		// 16-color: every palette region, kind code 3, ties and channel extremes
		set_depth(tpd_pkg::DEPTH_16);
		send_color(make_item(tpd_pkg::KIND_NONE, 8'd255, 8'hFF, 8'hFF, 8'hFF));
		send_color(make_item(KIND_UNUSED, 8'd200, 8'h80, 8'h80, 8'h80));
		send_color(make_item(tpd_pkg::KIND_INDEX, 8'd0, 8'hFF, 8'hFF, 8'hFF));
		send_color(make_item(tpd_pkg::KIND_INDEX, 8'd15, 8'h00, 8'h00, 8'h00));
		send_color(make_item(tpd_pkg::KIND_INDEX, 8'd16, 8'h12, 8'h34, 8'h56));
		send_color(make_item(tpd_pkg::KIND_INDEX, 8'd231, 8'h00, 8'h00, 8'h00));
		send_color(make_item(tpd_pkg::KIND_INDEX, 8'd232, 8'hFF, 8'h00, 8'hFF));
		send_color(make_item(tpd_pkg::KIND_INDEX, 8'd255, 8'h00, 8'hFF, 8'h00));
		send_color(make_item(tpd_pkg::KIND_RGB, 8'd255, 8'h00, 8'h00, 8'h00));
		send_color(make_item(tpd_pkg::KIND_RGB, 8'd0, 8'hFF, 8'hFF, 8'hFF));
		// equally far from black and from blue: black must win
		send_color(make_item(tpd_pkg::KIND_RGB, 8'd77, 8'd0, 8'd0, 8'd119));

		// 256-color: index passes, RGB extremes, cube/gray tie
		set_depth(tpd_pkg::DEPTH_256);
		send_color(make_item(tpd_pkg::KIND_INDEX, 8'd7, 8'hFF, 8'hFF, 8'hFF));
		send_color(make_item(tpd_pkg::KIND_RGB, 8'd0, 8'h00, 8'h00, 8'h00));
		send_color(make_item(tpd_pkg::KIND_RGB, 8'd255, 8'hFF, 8'hFF, 8'hFF));
		// midway between cube black and the darkest gray step
		send_color(make_item(tpd_pkg::KIND_RGB, 8'd99, 8'd4, 8'd4, 8'd4));

		// Monochrome drops everything
		set_depth(tpd_pkg::DEPTH_MONO);
		send_color(make_item(tpd_pkg::KIND_INDEX, 8'd42, 8'h00, 8'h00, 8'h00));
		send_color(make_item(tpd_pkg::KIND_RGB, 8'd0, 8'hC0, 8'h40, 8'h20));
		send_color(make_item(tpd_pkg::KIND_NONE, 8'd0, 8'h00, 8'h00, 8'h00));

		// Random segments: sender-light/receiver-heavy idling, then swapped,
		// then full rate
		for (int s = 0; s < SEGMENTS; s++) begin
			set_depth(seg_depth[s]);
			if (s < 4) begin
				send_idle_pct = 14;
				recv_idle_pct = 62;
			end else if (s < 7) begin
				send_idle_pct = 62;
				recv_idle_pct = 14;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int k = 0; k < SEG_ITEMS; k++) begin
				// park the consumer while requests keep coming
				if ((s == 1 || s == 7) && k == 20)
					hold_req = 1'b1;
				// pause mid-stream until everything is back
				if (s == 2 && k == 30)
					wait_drained();
				send_color(random_color());
			end
		end

		// Drain, then watch a while longer for stray results
		wait_drained();
		repeat (300) @(posedge clk);
		while (sb.pending_colors.size() != 0)
			sb.report_mismatch("missing result, kind",
				-1, sb.pending_colors.pop_front().out_kind);

		$display("Covered %0d requests over %0d depth writes, %0d results checked,",
			sent, depth_writes, sb.checked);
		$display("all four depths with none, index, RGB and kind-3 colors; %0d mismatches",
			sb.mismatches);
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
